>>> rtl/grid_astar_next_step_unit_defines.svh
// ----------------------------------------------------------------------------
// Grid next-step finder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_NEXT_STEP_UNIT_DEFINES_SVH
`define GRID_ASTAR_NEXT_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define GANS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GANS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gans_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gans_pkg
// Types and constants of the grid next-step finder.
// ----------------------------------------------------------------------------
package gans_pkg;

  localparam int X_W   = 5;
  localparam int Y_W   = 4;
  localparam int DIR_W = 3;

  localparam int GRID_COLS_DEF = 32;
  localparam int GRID_ROWS_DEF = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_NONE  = 3'd4
  } dir_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_QCLR,
    ST_SEED,
    ST_SCAN,
    ST_TAIL,
    ST_SELECT,
    ST_CLOSE,
    ST_NB_RD,
    ST_NB_CHK,
    ST_TR_RD,
    ST_TR_CHK,
    ST_FB_RD,
    ST_FB_CHK,
    ST_DONE
  } state_e;

endpackage

>>> rtl/grid_astar_next_step_unit.sv
`timescale 1ns / 1ps
// Write item: the transfer moves to ST_DONE, which registers the result and returns to ST_IDLE.
// Query: a clearing sweep over the node memory and a seed write, then per expansion a scan of
// every cell, a select, a close and the neighbour checks; trace-back reads and checks one path
// step at a time; the greedy fallback runs when no path is traced. One item at a time; a result
// not yet taken holds the next one back. Scan rate set by the node memory's single read port.
// After reset a clearing pass runs over both memories.
// ----------------------------------------------------------------------------
// grid_astar_next_step_unit
// Grid map with A* next-step query and greedy fallback, sequenced over memories.
// ----------------------------------------------------------------------------
`include "grid_astar_next_step_unit_defines.svh"

module grid_astar_next_step_unit #(
  parameter int GRID_COLS = gans_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gans_pkg::GRID_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [gans_pkg::X_W-1:0]   cell_x_i,
  input  logic [gans_pkg::Y_W-1:0]   cell_y_i,
  input  logic                       cell_blocked_i,
  input  logic [gans_pkg::X_W-1:0]   start_x_i,
  input  logic [gans_pkg::Y_W-1:0]   start_y_i,
  input  logic [gans_pkg::X_W-1:0]   target_x_i,
  input  logic [gans_pkg::Y_W-1:0]   target_y_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gans_pkg::DIR_W-1:0] step_direction_o,
  output logic                       goal_reached_o
);
  import gans_pkg::*;

  localparam int CELLS  = GRID_COLS * GRID_ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = CELL_W + 1;
  localparam int COST_W = $clog2(CELLS + GRID_COLS + GRID_ROWS);
  localparam int NODE_W = COST_W + 4;
  localparam int OPEN_B = NODE_W - 1;
  localparam int CLSD_B = NODE_W - 2;

  function automatic logic [CELL_W-1:0] cidx(input logic [X_W-1:0] x,
                                             input logic [Y_W-1:0] y);
    cidx = CELL_W'(x) * CELL_W'(GRID_ROWS) + CELL_W'(y);
  endfunction

  function automatic logic in_grid(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    in_grid = (int'(x) < GRID_COLS) && (int'(y) < GRID_ROWS);
  endfunction

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [X_W-1:0]    scan_x_q, rdx_q, best_x_q, cur_x_q, sx_q, tx_q;
  logic [Y_W-1:0]    scan_y_q, rdy_q, best_y_q, cur_y_q, sy_q, ty_q;
  logic              rdv_q, any_q;
  logic [CELL_W-1:0] best_idx_q;
  logic [COST_W-1:0] best_g_q, best_f_q;
  logic [1:0]        best_par_q, dir_cnt_q;
  dir_e              res_dir_q, out_dir_q;
  logic              res_found_q, out_valid_q, out_found_q;

  // memory controls
  logic              node_we, blk_we, blk_wdata;
  logic [CELL_W-1:0] wr_addr, rd_addr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic              blk_rdata;

  gans_store #(.CELLS(CELLS), .NODE_W(NODE_W)) u_store (
    .clk_i       (clk_i),
    .node_we_i   (node_we),
    .blk_we_i    (blk_we),
    .wr_addr_i   (wr_addr),
    .node_wdata_i(node_wdata),
    .blk_wdata_i (blk_wdata),
    .rd_addr_i   (rd_addr),
    .node_rdata_o(node_rdata),
    .blk_rdata_o (blk_rdata)
  );

  logic              rd_open;
  logic [COST_W-1:0] rd_cost, f_val, g_next;
  logic [1:0]        rd_par;
  logic              f_lt;

  assign rd_open = node_rdata[OPEN_B];
  assign rd_cost = node_rdata[COST_W+1:2];
  assign rd_par  = node_rdata[1:0];
  assign g_next  = best_g_q + COST_W'(1);

  gans_fcalc #(.COST_W(COST_W)) u_fcalc (
    .x_i     (rdx_q),
    .y_i     (rdy_q),
    .tx_i    (tx_q),
    .ty_i    (ty_q),
    .g_i     (rd_cost),
    .best_f_i(best_f_q),
    .f_o     (f_val),
    .lt_o    (f_lt)
  );

  logic in_xfer, out_xfer, last_cnt, query_ok;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign last_cnt   = (cnt_q == CNT_W'(CELLS - 1));
  assign query_ok   = in_grid(start_x_i, start_y_i) && in_grid(target_x_i, target_y_i) &&
                      !((start_x_i == target_x_i) && (start_y_i == target_y_i));

  // neighbour of the expanded cell
  logic           nb_ok;
  logic [X_W-1:0] nb_x;
  logic [Y_W-1:0] nb_y;
  always_comb begin
    nb_ok = 1'b0;
    nb_x  = best_x_q;
    nb_y  = best_y_q;
    unique case (dir_e'({1'b0, dir_cnt_q}))
      DIR_UP:    begin nb_ok = (best_y_q != '0); nb_y = best_y_q - Y_W'(1); end
      DIR_DOWN:  begin nb_ok = (int'(best_y_q) + 1 < GRID_ROWS); nb_y = best_y_q + Y_W'(1); end
      DIR_LEFT:  begin nb_ok = (best_x_q != '0); nb_x = best_x_q - X_W'(1); end
      DIR_RIGHT: begin nb_ok = (int'(best_x_q) + 1 < GRID_COLS); nb_x = best_x_q + X_W'(1); end
      default:   nb_ok = 1'b0;
    endcase
  end

  // parent of the traced cell: step back against the stored direction
  logic           pa_ok;
  logic [X_W-1:0] pa_x;
  logic [Y_W-1:0] pa_y;
  always_comb begin
    pa_ok = 1'b0;
    pa_x  = cur_x_q;
    pa_y  = cur_y_q;
    unique case (dir_e'({1'b0, rd_par}))
      DIR_UP:    begin pa_ok = (int'(cur_y_q) + 1 < GRID_ROWS); pa_y = cur_y_q + Y_W'(1); end
      DIR_DOWN:  begin pa_ok = (cur_y_q != '0); pa_y = cur_y_q - Y_W'(1); end
      DIR_LEFT:  begin pa_ok = (int'(cur_x_q) + 1 < GRID_COLS); pa_x = cur_x_q + X_W'(1); end
      DIR_RIGHT: begin pa_ok = (cur_x_q != '0); pa_x = cur_x_q - X_W'(1); end
      default:   pa_ok = 1'b0;
    endcase
  end

  // fallback candidate: right, left, down, up
  logic           fb_ok;
  logic [X_W-1:0] fb_x;
  logic [Y_W-1:0] fb_y;
  dir_e           fb_dir;
  always_comb begin
    fb_x = sx_q;
    fb_y = sy_q;
    unique case (dir_cnt_q)
      2'd0: begin
        fb_dir = DIR_RIGHT; fb_x = sx_q + X_W'(1);
        fb_ok  = (sx_q < tx_q) && (int'(sx_q) + 1 < GRID_COLS);
      end
      2'd1: begin
        fb_dir = DIR_LEFT; fb_x = sx_q - X_W'(1);
        fb_ok  = (sx_q > tx_q) && (sx_q != '0);
      end
      2'd2: begin
        fb_dir = DIR_DOWN; fb_y = sy_q + Y_W'(1);
        fb_ok  = (sy_q < ty_q) && (int'(sy_q) + 1 < GRID_ROWS);
      end
      default: begin
        fb_dir = DIR_UP; fb_y = sy_q - Y_W'(1);
        fb_ok  = (sy_q > ty_q) && (sy_q != '0);
      end
    endcase
  end

  logic nb_take;
  assign nb_take = !blk_rdata && !node_rdata[CLSD_B] && (!rd_open || (g_next < rd_cost));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:   if (last_cnt) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (operation_i == OP_QUERY && query_ok) ? ST_QCLR : ST_DONE;
        end
      end
      ST_QCLR:   if (last_cnt) state_d = ST_SEED;
      ST_SEED:   state_d = ST_SCAN;
      ST_SCAN:   if (last_cnt) state_d = ST_TAIL;
      ST_TAIL:   state_d = ST_SELECT;
      ST_SELECT: begin
        if (!any_q) begin
          state_d = ST_FB_RD;
        end else if (best_x_q == tx_q && best_y_q == ty_q) begin
          state_d = ST_TR_RD;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE:  state_d = ST_NB_RD;
      ST_NB_RD: begin
        if (nb_ok) state_d = ST_NB_CHK;
        else if (dir_cnt_q == 2'd3) state_d = ST_SCAN;
      end
      ST_NB_CHK: state_d = (dir_cnt_q == 2'd3) ? ST_SCAN : ST_NB_RD;
      ST_TR_RD:  state_d = ST_TR_CHK;
      ST_TR_CHK: begin
        if (!pa_ok) state_d = ST_FB_RD;
        else if (pa_x == sx_q && pa_y == sy_q) state_d = ST_DONE;
        else if (last_cnt) state_d = ST_FB_RD;
        else state_d = ST_TR_RD;
      end
      ST_FB_RD: begin
        if (fb_ok) state_d = ST_FB_CHK;
        else if (dir_cnt_q == 2'd3) state_d = ST_DONE;
      end
      ST_FB_CHK: begin
        if (!blk_rdata || dir_cnt_q == 2'd3) state_d = ST_DONE;
        else state_d = ST_FB_RD;
      end
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_INIT;
    endcase
  end

  // memory controls
  always_comb begin
    node_we    = 1'b0;
    blk_we     = 1'b0;
    blk_wdata  = 1'b0;
    wr_addr    = cnt_q[CELL_W-1:0];
    node_wdata = '0;
    rd_addr    = cnt_q[CELL_W-1:0];
    unique case (state_q)
      ST_INIT: begin
        node_we = 1'b1;
        blk_we  = 1'b1;
      end
      ST_IDLE: begin
        wr_addr   = cidx(cell_x_i, cell_y_i);
        blk_wdata = cell_blocked_i;
        blk_we    = in_xfer && (operation_i == OP_WRITE) && in_grid(cell_x_i, cell_y_i);
      end
      ST_QCLR: node_we = 1'b1;
      ST_SEED: begin
        node_we    = 1'b1;
        wr_addr    = cidx(sx_q, sy_q);
        node_wdata = NODE_W'(1) << OPEN_B;
      end
      ST_CLOSE: begin
        node_we    = 1'b1;
        wr_addr    = best_idx_q;
        node_wdata = {1'b0, 1'b1, best_g_q, best_par_q};
      end
      ST_NB_RD:  rd_addr = cidx(nb_x, nb_y);
      ST_NB_CHK: begin
        wr_addr    = cidx(nb_x, nb_y);
        node_we    = nb_take;
        node_wdata = {1'b1, 1'b0, g_next, dir_cnt_q};
      end
      ST_TR_RD:  rd_addr = cidx(cur_x_q, cur_y_q);
      ST_FB_RD:  rd_addr = cidx(fb_x, fb_y);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= (state_q == ST_SCAN);
      // trace-back counts path steps across its read/check pairs
      if (state_q == ST_TR_CHK) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (state_d != state_q && state_q != ST_TR_RD) begin
        cnt_q <= '0;
      end else if (state_q == ST_INIT || state_q == ST_QCLR || state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_SEED || state_q == ST_CLOSE) begin
        any_q <= 1'b0;
      end else if (rdv_q && rd_open && (!any_q || f_lt)) begin
        any_q <= 1'b1;
      end
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEED || state_q == ST_CLOSE) begin
      scan_x_q <= '0;
      scan_y_q <= '0;
    end else if (state_q == ST_SCAN) begin
      if (int'(scan_y_q) == GRID_ROWS - 1) begin
        scan_y_q <= '0;
        scan_x_q <= scan_x_q + X_W'(1);
      end else begin
        scan_y_q <= scan_y_q + Y_W'(1);
      end
    end
    rdx_q <= scan_x_q;
    rdy_q <= scan_y_q;

    if (rdv_q && rd_open && (!any_q || f_lt)) begin
      best_f_q   <= f_val;
      best_g_q   <= rd_cost;
      best_par_q <= rd_par;
      best_x_q   <= rdx_q;
      best_y_q   <= rdy_q;
      best_idx_q <= cidx(rdx_q, rdy_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        sx_q        <= start_x_i;
        sy_q        <= start_y_i;
        tx_q        <= target_x_i;
        ty_q        <= target_y_i;
        res_dir_q   <= DIR_NONE;
        res_found_q <= 1'b0;
      end
      ST_SELECT: begin
        dir_cnt_q <= '0;
        cur_x_q   <= tx_q;
        cur_y_q   <= ty_q;
      end
      ST_CLOSE:  dir_cnt_q <= '0;
      ST_NB_RD:  if (!nb_ok) dir_cnt_q <= dir_cnt_q + 2'd1;
      ST_NB_CHK: dir_cnt_q <= dir_cnt_q + 2'd1;
      ST_TR_CHK: begin
        cur_x_q   <= pa_x;
        cur_y_q   <= pa_y;
        dir_cnt_q <= '0;
        if (pa_ok && pa_x == sx_q && pa_y == sy_q) begin
          res_dir_q   <= dir_e'({1'b0, rd_par});
          res_found_q <= 1'b1;
        end
      end
      ST_FB_RD:  if (!fb_ok) dir_cnt_q <= dir_cnt_q + 2'd1;
      ST_FB_CHK: begin
        if (!blk_rdata) res_dir_q <= fb_dir;
        dir_cnt_q <= dir_cnt_q + 2'd1;
      end
      default: ;
    endcase

    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_dir_q   <= res_dir_q;
      out_found_q <= res_found_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_direction_o = out_dir_q;
  assign goal_reached_o   = out_found_q;

  `GANS_ASSERT_NXT(a_accept_next, in_xfer, (state_q == ST_QCLR || state_q == ST_DONE), "idle")
  `GANS_ASSERT_NOW(a_found_dir, (state_q == ST_DONE && res_found_q), (res_dir_q != DIR_NONE), "no dir")
  `GANS_ASSERT_NOW(a_scan_data, rdv_q, ($past(state_q) == ST_SCAN), "scan data without a scan read")

endmodule

>>> rtl/gans_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gans_store
// Node memory (open, closed, cost, parent) and blocked-cell memory.
// ----------------------------------------------------------------------------
module gans_store #(
  parameter int CELLS  = 512,
  parameter int NODE_W = 14
) (
  input  logic                       clk_i,
  input  logic                       node_we_i,
  input  logic                       blk_we_i,
  input  logic [$clog2(CELLS)-1:0]   wr_addr_i,
  input  logic [NODE_W-1:0]          node_wdata_i,
  input  logic                       blk_wdata_i,
  input  logic [$clog2(CELLS)-1:0]   rd_addr_i,
  output logic [NODE_W-1:0]          node_rdata_o,
  output logic                       blk_rdata_o
);

  logic [NODE_W-1:0] node_mem [CELLS];
  logic              blk_mem  [CELLS];

  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      node_mem[wr_addr_i] <= node_wdata_i;
    end
    node_rdata_o <= node_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we_i) begin
      blk_mem[wr_addr_i] <= blk_wdata_i;
    end
    blk_rdata_o <= blk_mem[rd_addr_i];
  end

endmodule

>>> rtl/gans_fcalc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gans_fcalc
// Combinational f = g + Manhattan distance unit with compare against current best.
// ----------------------------------------------------------------------------
module gans_fcalc #(
  parameter int COST_W = 10
) (
  input  logic [gans_pkg::X_W-1:0] x_i,
  input  logic [gans_pkg::Y_W-1:0] y_i,
  input  logic [gans_pkg::X_W-1:0] tx_i,
  input  logic [gans_pkg::Y_W-1:0] ty_i,
  input  logic [COST_W-1:0]        g_i,
  input  logic [COST_W-1:0]        best_f_i,
  output logic [COST_W-1:0]        f_o,
  output logic                     lt_o
);
  import gans_pkg::*;

  logic [X_W-1:0] dx;
  logic [Y_W-1:0] dy;

  always_comb begin
    dx   = (x_i >= tx_i) ? (x_i - tx_i) : (tx_i - x_i);
    dy   = (y_i >= ty_i) ? (y_i - ty_i) : (ty_i - y_i);
    f_o  = g_i + COST_W'(dx) + COST_W'(dy);
    lt_o = (f_o < best_f_i);
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid next-step finder. A directed table covers
// corner moves, map writes and fallback pockets. Random map edits and queries
// follow under three idle patterns, with a receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import gans_pkg::*;

  localparam int COLS     = 32;
  localparam int ROWS     = 16;
  localparam int CELLS    = COLS * ROWS;
  localparam int COST_INF = 1000000;
  localparam int WD_LIMIT = 1500000;
  localparam int DRAIN    = 2000;
  localparam int DX[4] = '{0, 0, -1, 1};
  localparam int DY[4] = '{-1, 1, 0, 0};

  typedef struct {
    op_e        op;
    logic [4:0] cx;
    logic [3:0] cy;
    logic       cb;
    logic [4:0] sx;
    logic [3:0] sy;
    logic [4:0] tx;
    logic [3:0] ty;
    bit         typed;
    dir_e       dir;
    bit         found;
  } stim_t;

  typedef struct {
    dir_e dir;
    bit   found;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [4:0] cell_x_i = '0;
  logic [3:0] cell_y_i = '0;
  logic cell_blocked_i = 1'b0;
  logic [4:0] start_x_i = '0;
  logic [3:0] start_y_i = '0;
  logic [4:0] target_x_i = '0;
  logic [3:0] target_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] step_direction_o;
  logic goal_reached_o;

  always #5 clk_i = ~clk_i;

  grid_astar_next_step_unit DUT (.*);

  // predictor state
  bit         wall[CELLS];
  int         cost[CELLS];
  bit         opn[CELLS];
  bit         cls[CELLS];
  logic [1:0] par[CELLS];

  step_t pending_steps[$];
  int    snd_pct, rcv_pct, hold_cnt;
  int    errors, n_query, n_found, n_write, n_checked;
  int    idle_cnt;

  function automatic bit clear_at(int x, int y);
    return x >= 0 && x < COLS && y >= 0 && y < ROWS && !wall[x * ROWS + y];
  endfunction

  function automatic int absi(int v);
    return v < 0 ? -v : v;
  endfunction

  // A* from (sx,sy) to (tx,ty); DIR_NONE when the target is never selected or the trace-back fails
  function automatic dir_e astar_first_step(int sx, int sy, int tx, int ty);
    int best, best_f, f, cx, cy, nx, ny, n, g, x, y, px, py, goal;
    bit any;
    goal = tx * ROWS + ty;
    for (int i = 0; i < CELLS; i++) begin
      cost[i] = COST_INF;
      opn[i] = 0;
      cls[i] = 0;
    end
    cost[sx * ROWS + sy] = 0;
    opn[sx * ROWS + sy] = 1;
    forever begin
      any = 0;
      best = 0;
      best_f = COST_INF;
      for (int i = 0; i < CELLS; i++) begin
        if (opn[i]) begin
          f = cost[i] + absi(i / ROWS - tx) + absi(i % ROWS - ty);
          if (f < best_f) begin
            best_f = f;
            best = i;
            any = 1;
          end
        end
      end
      if (!any) return DIR_NONE;
      if (best == goal) break;
      opn[best] = 0;
      cls[best] = 1;
      cx = best / ROWS;
      cy = best % ROWS;
      for (int d = 0; d < 4; d++) begin
        nx = cx + DX[d];
        ny = cy + DY[d];
        if (!clear_at(nx, ny)) continue;
        n = nx * ROWS + ny;
        if (cls[n]) continue;
        g = cost[best] + 1;
        if (!opn[n] || g < cost[n]) begin
          par[n] = d[1:0];
          cost[n] = g;
          opn[n] = 1;
        end
      end
    end
    x = tx;
    y = ty;
    for (int s = 0; s < CELLS; s++) begin
      px = x - DX[par[x * ROWS + y]];
      py = y - DY[par[x * ROWS + y]];
      if (px < 0 || px >= COLS || py < 0 || py >= ROWS) return DIR_NONE;
      if (px == sx && py == sy) return dir_e'({1'b0, par[x * ROWS + y]});
      x = px;
      y = py;
    end
    return DIR_NONE;
  endfunction

  // applies one item to the map and returns the step it should produce
  function automatic step_t plan_step(stim_t it);
    step_t r;
    r.dir = DIR_NONE;
    r.found = 0;
    if (it.op == OP_WRITE) begin
      wall[it.cx * ROWS + it.cy] = it.cb;
    end else if (!(it.sx == it.tx && it.sy == it.ty)) begin
      r.dir = astar_first_step(it.sx, it.sy, it.tx, it.ty);
      if (r.dir != DIR_NONE) r.found = 1;
      else if (it.sx < it.tx && clear_at(it.sx + 1, it.sy)) r.dir = DIR_RIGHT;
      else if (it.sx > it.tx && clear_at(it.sx - 1, it.sy)) r.dir = DIR_LEFT;
      else if (it.sy < it.ty && clear_at(it.sx, it.sy + 1)) r.dir = DIR_DOWN;
      else if (it.sy > it.ty && clear_at(it.sx, it.sy - 1)) r.dir = DIR_UP;
    end
    return r;
  endfunction

  function automatic stim_t mk(op_e op, int cx, int cy, int cb, int sx, int sy,
                               int tx, int ty, bit typed = 0, dir_e dir = DIR_NONE,
                               bit found = 0);
    stim_t s;
    s.op = op;
    s.cx = 5'(cx);
    s.cy = 4'(cy);
    s.cb = 1'(cb);
    s.sx = 5'(sx);
    s.sy = 4'(sy);
    s.tx = 5'(tx);
    s.ty = 4'(ty);
    s.typed = typed;
    s.dir = dir;
    s.found = found;
    return s;
  endfunction

  task automatic send_item(stim_t it);
    step_t p;
    p = plan_step(it);
    if (it.typed) begin
      p.dir = it.dir;
      p.found = it.found;
    end
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= it.op;
    cell_x_i <= it.cx;
    cell_y_i <= it.cy;
    cell_blocked_i <= it.cb;
    start_x_i <= it.sx;
    start_y_i <= it.sy;
    target_x_i <= it.tx;
    target_y_i <= it.ty;
    do @(posedge clk_i); while (!in_ready_o);
    pending_steps.push_back(p);
    if (it.op == OP_WRITE) n_write++;
    else n_query++;
  endtask

  function automatic stim_t random_item();
    stim_t s;
    int tries;
    s = mk(op_e'($urandom_range(1)), $urandom_range(31), $urandom_range(15),
           $urandom_range(9) < 7, $urandom_range(31), $urandom_range(15),
           $urandom_range(31), $urandom_range(15));
    if (s.op == OP_QUERY && $urandom_range(19) != 0) begin
      // keep targets clear and reachable so searches stay short
      for (tries = 0; tries < 20; tries++) begin
        if ($urandom_range(9) != 0) begin
          s.tx = 5'((s.sx + $urandom_range(20) + 22) % COLS);
          s.ty = 4'((s.sy + $urandom_range(12) + 10) % ROWS);
        end
        if (clear_at(s.tx, s.ty) && (s.sx != s.tx || s.sy != s.ty) &&
            astar_first_step(s.sx, s.sy, s.tx, s.ty) != DIR_NONE) break;
        s.sx = 5'($urandom_range(31));
        s.sy = 4'($urandom_range(15));
        s.tx = 5'($urandom_range(31));
        s.ty = 4'($urandom_range(15));
      end
    end else if (s.op == OP_QUERY) begin
      s.tx = s.sx;
      s.ty = s.sy;
    end
    return s;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    step_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result dir=%0d found=%0d", $time,
                 step_direction_o, goal_reached_o);
        errors++;
      end else begin
        e = pending_steps.pop_front();
        if (step_direction_o !== e.dir) begin
          $display("%0t: step_direction expected %0d actual %0d", $time, e.dir,
                   step_direction_o);
          errors++;
        end
        if (goal_reached_o !== e.found) begin
          $display("%0t: goal_reached expected %0d actual %0d", $time, e.found,
                   goal_reached_o);
          errors++;
        end
        if (e.found) n_found++;
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_steps.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_t tbl[$];
    int pocket[9][2];
    errors = 0;
    n_query = 0;
    n_found = 0;
    n_write = 0;
    n_checked = 0;
    idle_cnt = 0;
    hold_cnt = 0;
    snd_pct = 37;
    rcv_pct = 82;
    for (int i = 0; i < CELLS; i++) wall[i] = 0;

    // open map moves
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 5, 5, 5, 5, 1, DIR_NONE, 0));
    tbl.push_back(mk(OP_QUERY, 31, 15, 1, 0, 0, 1, 0, 1, DIR_RIGHT, 1));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 31, 15, 30, 15, 1, DIR_LEFT, 1));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 3, 0, 3, 15, 1, DIR_DOWN, 1));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 3, 15, 3, 0, 1, DIR_UP, 1));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 31, 15));
    tbl.push_back(mk(OP_WRITE, 31, 15, 1, 31, 15, 0, 0, 1, DIR_NONE, 0));
    tbl.push_back(mk(OP_WRITE, 0, 0, 1, 0, 0, 31, 15, 1, DIR_NONE, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 2, 1));
    tbl.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 1, DIR_NONE, 0));
    // two-cell pocket (10,8)-(11,8): no path, fallback only
    tbl.push_back(mk(OP_WRITE, 10, 7, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 11, 7, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 10, 9, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 11, 9, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 9, 8, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 12, 8, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 10, 8, 20, 8, 1, DIR_RIGHT, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 11, 8, 0, 8, 1, DIR_LEFT, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 10, 8, 10, 0, 1, DIR_NONE, 0));
    // blocked target next to the pocket
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 11, 8, 12, 8, 1, DIR_NONE, 0));
    // reshape to an L so the vertical fallbacks fire
    tbl.push_back(mk(OP_WRITE, 9, 9, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 10, 10, 1, 0, 0, 0, 0));
    tbl.push_back(mk(OP_WRITE, 10, 9, 0, 0, 0, 0, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 10, 9, 10, 0, 1, DIR_UP, 0));
    tbl.push_back(mk(OP_QUERY, 0, 0, 0, 10, 8, 10, 15, 1, DIR_DOWN, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (tbl[i]) send_item(tbl[i]);

    // open the pocket again so random targets stay reachable
    pocket = '{'{10, 7}, '{11, 7}, '{11, 9}, '{9, 8}, '{12, 8}, '{9, 9},
               '{10, 10}, '{31, 15}, '{0, 0}};
    foreach (pocket[i]) send_item(mk(OP_WRITE, pocket[i][0], pocket[i][1], 0, 0, 0, 0, 0));

    for (int i = 0; i < 25; i++) send_item(random_item());

    snd_pct = 82;
    rcv_pct = 37;
    for (int i = 0; i < 25; i++) send_item(random_item());
    in_valid_i <= 1'b0;

    // sender waits for every outstanding step
    wait (pending_steps.size() == 0);
    snd_pct = 0;
    rcv_pct = 0;
    @(posedge clk_i);
    hold_cnt = 400;
    // two quick writes fill the output register and stall the input
    send_item(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_WRITE, 31, 15, 0, 0, 0, 0, 0));
    for (int i = 0; i < 15; i++) send_item(random_item());
    in_valid_i <= 1'b0;

    wait (pending_steps.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d map writes and %0d queries (%0d solved by search),", n_write,
             n_query, n_found);
    $display("%0d results checked across three idle patterns.", n_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> grid_astar_next_step_unit.f
+incdir+rtl
rtl/gans_pkg.sv
rtl/gans_store.sv
rtl/gans_fcalc.sv
rtl/grid_astar_next_step_unit.sv
tb/tb_top.sv
